[src/linear_kalman_filter_macros.svh]
// ----------------------------------------------------------------------------
// linear kalman filter assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef LINEAR_KALMAN_FILTER_MACROS_SVH
`define LINEAR_KALMAN_FILTER_MACROS_SVH

// implication checked every clock edge outside reset
`define LKF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/lkf_pkg.sv]
// ----------------------------------------------------------------------------
// lkf package
// shared types and constants of the kalman filter
// ----------------------------------------------------------------------------
`default_nettype none
package lkf_pkg;
   localparam logic [1:0] CMD_PREDICT = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [2:0] CSR_F  = 3'd0;
   localparam logic [2:0] CSR_H  = 3'd1;
   localparam logic [2:0] CSR_R  = 3'd2;
   localparam logic [2:0] CSR_U  = 3'd3;
   localparam logic [2:0] CSR_P0 = 3'd4;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_RESTART,
      OP_MUL,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_PRED_COMMIT,
      OP_UPD_COMMIT,
      OP_CAPTURE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] idx;
      logic       flag;
   } cmd_type;

   typedef struct packed {
      logic s_bad;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

[src/lkf_datapath.sv]
// ----------------------------------------------------------------------------
// lkf datapath
// state registers, one shared and three fixed multipliers, a restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module lkf_datapath
   import lkf_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  wire logic [63:0] f_reg,
   input  wire logic [31:0] h_reg,
   input  wire logic [14:0] r_reg,
   input  wire logic [31:0] u_reg,
   input  wire logic [63:0] p0_reg,
   input  wire logic signed [15:0] z_in,
   output logic [64:0]      result
);
   localparam int W = 80;

   logic signed [15:0] x_ff [2];
   logic signed [15:0] p_ff [4];
   logic signed [W-1:0] t_ff [12], t_in [12];
   logic signed [33:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [49:0] prod;
   logic signed [W-1:0] dst_old;
   logic [W-1:0] num_ff, quo_ff, rem_ff;
   logic [W-1:0] den_ff;
   logic         neg_ff;
   logic [6:0]   cnt_ff;
   logic [64:0]  result_ff;

   function automatic logic signed [15:0] lanef(input logic [63:0] w, input int k);
      lanef = w[16*k +: 16];
   endfunction

   function automatic logic signed [W-1:0] rshr(input logic signed [W-1:0] v,
                                                 input int s);
      logic signed [W-1:0] t;
      t = v + (W'(1) <<< (s - 1));
      rshr = t >>> s;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [W-1:0] v);
      if (v > W'(32767)) sat16 = 16'sh7fff;
      else if (v < -W'(32768)) sat16 = 16'sh8000;
      else sat16 = v[15:0];
   endfunction

   function automatic logic signed [W-1:0] sat32(input logic signed [W-1:0] v);
      if (v > W'(64'sh7fffffff)) sat32 = W'(64'sh7fffffff);
      else if (v < -W'(64'sh80000000)) sat32 = -W'(64'sh80000000);
      else sat32 = v;
   endfunction

   // multiply schedule: index selects operands, dest, and whether to accumulate
   // temps: 0 xa 1 xb 2-5 fp 6-9 pp 10 tmp 11 s
   logic [3:0] dst;
   logic       acc;
   logic signed [15:0] hh0, hh1;
   assign hh0 = lanef({32'd0, h_reg}, 0);
   assign hh1 = lanef({32'd0, h_reg}, 1);

   always_comb begin
      mul_a = '0; mul_b = '0; dst = 4'd10; acc = 1'b0;
      unique case (cmd.idx)
         // predict: x, FP, FPF'
         5'd0:  begin mul_a = 34'(lanef(f_reg,0)); mul_b = x_ff[0]; dst = 4'd0; end
         5'd1:  begin mul_a = 34'(lanef(f_reg,1)); mul_b = x_ff[1]; dst = 4'd0; acc = 1'b1; end
         5'd2:  begin mul_a = 34'(lanef(f_reg,2)); mul_b = x_ff[0]; dst = 4'd1; end
         5'd3:  begin mul_a = 34'(lanef(f_reg,3)); mul_b = x_ff[1]; dst = 4'd1; acc = 1'b1; end
         5'd4:  begin mul_a = 34'(lanef(f_reg,0)); mul_b = p_ff[0]; dst = 4'd2; end
         5'd5:  begin mul_a = 34'(lanef(f_reg,1)); mul_b = p_ff[2]; dst = 4'd2; acc = 1'b1; end
         5'd6:  begin mul_a = 34'(lanef(f_reg,0)); mul_b = p_ff[1]; dst = 4'd3; end
         5'd7:  begin mul_a = 34'(lanef(f_reg,1)); mul_b = p_ff[3]; dst = 4'd3; acc = 1'b1; end
         5'd8:  begin mul_a = 34'(lanef(f_reg,2)); mul_b = p_ff[0]; dst = 4'd4; end
         5'd9:  begin mul_a = 34'(lanef(f_reg,3)); mul_b = p_ff[2]; dst = 4'd4; acc = 1'b1; end
         5'd10: begin mul_a = 34'(lanef(f_reg,2)); mul_b = p_ff[1]; dst = 4'd5; end
         5'd11: begin mul_a = 34'(lanef(f_reg,3)); mul_b = p_ff[3]; dst = 4'd5; acc = 1'b1; end
         5'd12: begin mul_a = 34'(t_ff[2]); mul_b = lanef(f_reg,0); dst = 4'd6; end
         5'd13: begin mul_a = 34'(t_ff[3]); mul_b = lanef(f_reg,1); dst = 4'd6; acc = 1'b1; end
         5'd14: begin mul_a = 34'(t_ff[2]); mul_b = lanef(f_reg,2); dst = 4'd7; end
         5'd15: begin mul_a = 34'(t_ff[3]); mul_b = lanef(f_reg,3); dst = 4'd7; acc = 1'b1; end
         5'd16: begin mul_a = 34'(t_ff[4]); mul_b = lanef(f_reg,0); dst = 4'd8; end
         5'd17: begin mul_a = 34'(t_ff[5]); mul_b = lanef(f_reg,1); dst = 4'd8; acc = 1'b1; end
         5'd18: begin mul_a = 34'(t_ff[4]); mul_b = lanef(f_reg,2); dst = 4'd9; end
         5'd19: begin mul_a = 34'(t_ff[5]); mul_b = lanef(f_reg,3); dst = 4'd9; acc = 1'b1; end
         // update: hx -> 0, w -> 2,3, v -> 4,5, s -> 11
         5'd20: begin mul_a = 34'(hh0); mul_b = x_ff[0]; dst = 4'd0; end
         5'd21: begin mul_a = 34'(hh1); mul_b = x_ff[1]; dst = 4'd0; acc = 1'b1; end
         5'd22: begin mul_a = 34'(hh0); mul_b = p_ff[0]; dst = 4'd2; end
         5'd23: begin mul_a = 34'(hh1); mul_b = p_ff[2]; dst = 4'd2; acc = 1'b1; end
         5'd24: begin mul_a = 34'(hh0); mul_b = p_ff[1]; dst = 4'd3; end
         5'd25: begin mul_a = 34'(hh1); mul_b = p_ff[3]; dst = 4'd3; acc = 1'b1; end
         5'd26: begin mul_a = 34'(p_ff[0]); mul_b = hh0; dst = 4'd4; end
         5'd27: begin mul_a = 34'(p_ff[1]); mul_b = hh1; dst = 4'd4; acc = 1'b1; end
         5'd28: begin mul_a = 34'(p_ff[2]); mul_b = hh0; dst = 4'd5; end
         5'd29: begin mul_a = 34'(p_ff[3]); mul_b = hh1; dst = 4'd5; acc = 1'b1; end
         5'd30: begin mul_a = 34'(t_ff[2]); mul_b = hh0; dst = 4'd11; end
         5'd31: begin mul_a = 34'(t_ff[3]); mul_b = hh1; dst = 4'd11; acc = 1'b1; end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;
   assign dst_old = t_ff[dst];

   // divider numerator selection by idx of start; denominator is s plus R
   logic signed [W-1:0] sval, dnum;
   logic signed [33:0] dv, dw;
   logic signed [67:0] vw;
   assign sval = t_ff[11] + (W'(r_reg) <<< (2 * FRAC_BITS));
   assign dv = cmd.idx[2] ? 34'(t_ff[5]) : 34'(t_ff[4]);
   assign dw = cmd.idx[0] ? 34'(t_ff[3]) : 34'(t_ff[2]);
   assign vw = dv * dw;
   always_comb begin
      unique case (cmd.idx[2:0])
         3'd0: dnum = t_ff[4] <<< (2 * FRAC_BITS);
         3'd1: dnum = t_ff[5] <<< (2 * FRAC_BITS);
         3'd2, 3'd3, 3'd4, 3'd5: dnum = W'(vw);
         default: dnum = '0;
      endcase
   end

   logic [W:0] trial;
   logic [W-1:0] qres;
   assign trial = {rem_ff[W-2:0], num_ff[W-1]} - {1'b0, den_ff};
   assign qres = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_comb begin
      for (int i = 0; i < 12; i++) t_in[i] = t_ff[i];
      unique case (cmd.op)
         OP_MUL: t_in[dst] = acc ? dst_old + W'(prod) : W'(prod);
         OP_CAPTURE: begin
            // save division result into temp slot by idx
            unique case (cmd.idx[2:0])
               3'd0: t_in[6] = qres;
               3'd1: t_in[7] = qres;
               3'd2: t_in[8] = qres;
               3'd3: t_in[9] = qres;
               3'd4: t_in[1] = qres;
               3'd5: t_in[11] = qres;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      unique case (cmd.op)
         OP_DIV_START: begin
            // magnitude plus half the divisor gives round to nearest
            neg_ff <= dnum[W-1];
            num_ff <= (dnum[W-1] ? -dnum : dnum) + (sval >> 1);
            den_ff <= sval;
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= 7'(W - 1);
         end
         OP_DIV_STEP: begin
            num_ff <= num_ff << 1;
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[W-2:0], num_ff[W-1]};
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 7'd1;
         end
         default: ;
      endcase
   end
   assign stat.div_done = (cnt_ff == 7'd0);
   assign stat.s_bad = (sval <= 0);

   // gain times innovation for the mean correction
   logic signed [31:0] k0, k1;
   logic signed [29:0] yv;
   logic signed [61:0] ky0, ky1;
   assign k0 = 32'(sat32(t_ff[6]));
   assign k1 = 32'(sat32(t_ff[7]));
   assign yv = 30'(W'(z_in) - rshr(t_ff[0], FRAC_BITS));
   assign ky0 = k0 * yv;
   assign ky1 = k1 * yv;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff[0] <= '0; x_ff[1] <= '0;
         for (int i = 0; i < 4; i++) p_ff[i] <= '0;
      end else begin
         unique case (cmd.op)
            OP_RESTART: begin
               x_ff[0] <= '0; x_ff[1] <= '0;
               for (int i = 0; i < 4; i++) p_ff[i] <= lanef(p0_reg, i);
            end
            OP_PRED_COMMIT: begin
               x_ff[0] <= sat16(rshr(t_ff[0], FRAC_BITS) + W'(lanef({32'd0,u_reg},0)));
               x_ff[1] <= sat16(rshr(t_ff[1], FRAC_BITS) + W'(lanef({32'd0,u_reg},1)));
               for (int i = 0; i < 4; i++) p_ff[i] <= sat16(rshr(t_ff[6+i], 2*FRAC_BITS));
            end
            OP_UPD_COMMIT: begin
               // t6,t7 gains; t8..t9,t1,t11 covariance corrections; t0 hx
               x_ff[0] <= sat16(W'(x_ff[0]) + rshr(W'(ky0), FRAC_BITS));
               x_ff[1] <= sat16(W'(x_ff[1]) + rshr(W'(ky1), FRAC_BITS));
               p_ff[0] <= sat16(W'(p_ff[0]) - t_ff[8]);
               p_ff[1] <= sat16(W'(p_ff[1]) - t_ff[9]);
               p_ff[2] <= sat16(W'(p_ff[2]) - t_ff[1]);
               p_ff[3] <= sat16(W'(p_ff[3]) - t_ff[11]);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE && cmd.idx == 5'd31)
         result_ff <= {cmd.flag, p_ff[3], p_ff[0], x_ff[1], x_ff[0]};
   end
   assign result = result_ff;
endmodule
`default_nettype wire

[src/lkf_control.sv]
// ----------------------------------------------------------------------------
// lkf control
// sequences the multiply and divide steps of predict and update
// ----------------------------------------------------------------------------
`default_nettype none
module lkf_control
   import lkf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [1:0] req_cmd,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output cmd_type         cmd,
   input  stat_type        stat
);
   typedef enum logic [2:0] {S_IDLE, S_MUL, S_DSTART, S_DSTEP, S_CAP, S_COMMIT, S_DONE,
                             S_RESTART}
      state_type;
   state_type  state_ff;
   logic       upd_ff, flag_ff, vld_ff;
   logic [4:0] idx_ff, div_ff;

   assign req_tready = (state_ff == S_IDLE) && (!vld_ff || rsp_tready);
   assign rsp_tvalid = vld_ff;

   always_comb begin
      cmd = '{op: OP_NONE, idx: idx_ff, flag: flag_ff};
      unique case (state_ff)
         S_MUL:     cmd.op = OP_MUL;
         S_DSTART:  begin cmd.op = OP_DIV_START; cmd.idx = div_ff; end
         S_DSTEP:   begin cmd.op = OP_DIV_STEP;  cmd.idx = div_ff; end
         S_CAP:     begin cmd.op = OP_CAPTURE;   cmd.idx = div_ff; end
         S_COMMIT:  cmd.op = upd_ff ? OP_UPD_COMMIT : OP_PRED_COMMIT;
         S_RESTART: cmd.op = OP_RESTART;
         S_DONE:    begin cmd.op = OP_CAPTURE; cmd.idx = 5'd31; end
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0; idx_ff <= '0;
         div_ff <= '0; upd_ff <= 1'b0; flag_ff <= 1'b0;
      end else begin
         if (vld_ff && rsp_tready) vld_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               flag_ff <= 1'b0;
               upd_ff  <= (req_cmd == CMD_UPDATE);
               unique case (req_cmd)
                  CMD_PREDICT: begin idx_ff <= 5'd0; state_ff <= S_MUL; end
                  CMD_UPDATE:  begin idx_ff <= 5'd20; state_ff <= S_MUL; end
                  CMD_RESTART: state_ff <= S_RESTART;
                  default:     state_ff <= S_DONE;
               endcase
            end
            S_MUL: begin
               if (idx_ff == 5'd19) state_ff <= S_COMMIT;
               else if (idx_ff == 5'd31) begin
                  div_ff <= 5'd0; state_ff <= S_DSTART;
               end
               idx_ff <= idx_ff + 5'd1;
            end
            S_DSTART: if (stat.s_bad) begin
               flag_ff <= 1'b1; state_ff <= S_DONE;
            end else state_ff <= S_DSTEP;
            S_DSTEP: if (stat.div_done) state_ff <= S_CAP;
            S_CAP: if (div_ff == 5'd5) state_ff <= S_COMMIT;
               else begin div_ff <= div_ff + 5'd1; state_ff <= S_DSTART; end
            S_COMMIT: state_ff <= S_DONE;
            S_RESTART: state_ff <= S_DONE;
            S_DONE: begin vld_ff <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[src/linear_kalman_filter.sv]
// unused codes go straight to the response; restart loads P0 and zeroes x;
// predict and update take one shared multiplier step per product, and update then
// runs six divides (load, steps, capture); s+R <= 0 flags and skips the commit
// one request at a time; the next is taken once the response slot is free
// synchronous reset: state zeroed, registers to identity defaults
`default_nettype none
module linear_kalman_filter
   import lkf_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // command, measurement
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // estimate_first, estimate_second,
                                        // variance_first, variance_second
   output logic             rsp_tuser,  // singular_flag
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [63:0] f_ff, p0_ff;
   logic [31:0] h_ff, u_ff;
   logic [14:0] r_ff;
   logic signed [15:0] z_ff;
   cmd_type  cmd;
   stat_type stat;
   logic [64:0] result;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff <= 64'h0100_0000_0000_0100; h_ff <= 32'h100; r_ff <= 15'h100;
         u_ff <= '0; p0_ff <= 64'h0100_0000_0000_0100;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_F:  f_ff <= csr_data;
            CSR_H:  h_ff <= csr_data[31:0];
            CSR_R:  r_ff <= csr_data[14:0];
            CSR_U:  u_ff <= csr_data[31:0];
            CSR_P0: p0_ff <= csr_data;
            default: ;
         endcase
      end
      if (req_tvalid && req_tready) z_ff <= req_tdata[17:2];
   end

   lkf_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_cmd(req_tdata[1:0]),
      .rsp_tvalid, .rsp_tready, .cmd, .stat
   );

   lkf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .stat, .f_reg(f_ff), .h_reg(h_ff), .r_reg(r_ff),
      .u_reg(u_ff), .p0_reg(p0_ff), .z_in(z_ff), .result
   );

   assign rsp_tdata = result[63:0];
   assign rsp_tuser = result[64];
endmodule
`default_nettype wire

[src/lkf_checker.sv]
// ----------------------------------------------------------------------------
// lkf checker
// port-level checks of the kalman filter handshake
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_kalman_filter_macros.svh"
module lkf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   `LKF_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `LKF_ASSERT_NEXT(a_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `LKF_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `LKF_ASSERT_IMPL(a_flag, clock, reset, rsp_tvalid && rsp_tuser, rsp_tvalid)
endmodule
bind linear_kalman_filter lkf_checker u_chk (.*);
`default_nettype wire
